>>> sv/spq_pkg.sv
package spq_pkg;

    localparam int SPQ_CAPACITY      = 16;
    localparam int SPQ_PRIORITY_BITS = 4;
    localparam int SPQ_ID_BITS       = 16;

    // fixed widths of the transaction fields
    localparam int SPQ_PRIO_W = 4;
    localparam int SPQ_ID_W   = 16;
    localparam int SPQ_OCC_W  = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SERVE  = 1'b1
    } spq_cmd_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } spq_status_t;

    typedef struct packed {
        spq_cmd_t              command;
        logic [SPQ_PRIO_W-1:0] priority_req;
    } spq_in_t;

    typedef struct packed {
        spq_status_t           status;
        logic [SPQ_ID_W-1:0]   entry_id;
        logic [SPQ_PRIO_W-1:0] entry_priority;
        logic [SPQ_OCC_W-1:0]  occupancy;
    } spq_out_t;

    // shift control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic serve;
    } spq_ctrl_t;

endpackage

>>> sv/stable_priority_queue_top.sv
// Stable priority queue, sorted on insert, highest priority at the head.
// Input channel (s_valid/s_ready/s_data) carries a command: insert with a
// priority, or serve the head. Result channel (m_valid/m_ready/m_data)
// returns exactly one transaction per command: status, entry id, priority
// and occupancy after the command.
// Latency: result is valid the cycle after the command is accepted.
// Throughput: one command per cycle while s_ready is high; the whole row
// of cells compares against the new priority and shifts at once, so that
// row's compare-and-select path sets the cycle.
// Equal priorities keep arrival order. Inserts into a full queue return
// status full and consume no id; serve on an empty queue returns status
// empty. Ids start at 1 and wrap modulo 2^ID_BITS.
// Reset (aresetn low, synchronous): queue empty, next id 1, no result
// pending. Cell contents are not cleared; only held entries are ever read.
// Stall: the result sits in an output register; s_ready stays high while
// that register is empty or being drained, and drops while m_valid is
// held against a low m_ready.
module stable_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY      = SPQ_CAPACITY,
    parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS,
    parameter int ID_BITS       = SPQ_ID_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  spq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output spq_out_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      count_reg, count_next;
    logic [ID_BITS-1:0] seq_reg, seq_next;
    logic               m_valid_reg, m_valid_next;
    spq_out_t           m_data_reg, m_data_next;

    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    logic [PRIORITY_BITS-1:0] new_prio;
    spq_ctrl_t                ctrl;

    // neighbour chains: cell g sits at index g+1, ends are tied off
    logic                     keep_c [CAPACITY+1];
    logic [ID_BITS-1:0]       id_c   [CAPACITY+2];
    logic [PRIORITY_BITS-1:0] prio_c [CAPACITY+2];
    logic [CAPACITY-1:0]      occupied;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign new_prio = PRIORITY_BITS'(s_data.priority_req);

    assign ctrl.insert = accept && (s_data.command == CMD_INSERT) && !is_full;
    assign ctrl.serve  = accept && (s_data.command == CMD_SERVE) && !is_empty;

    assign keep_c[0]          = 1'b1;
    assign id_c[0]            = '0;
    assign prio_c[0]          = '0;
    assign id_c[CAPACITY+1]   = '0;
    assign prio_c[CAPACITY+1] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign occupied[g] = (CW'(g) < count_reg);

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .ID_BITS       (ID_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (occupied[g]),
            .new_id    (seq_reg),
            .new_prio  (new_prio),
            .prev_keep (keep_c[g]),
            .prev_id   (id_c[g]),
            .prev_prio (prio_c[g]),
            .next_id   (id_c[g+2]),
            .next_prio (prio_c[g+2]),
            .keep      (keep_c[g+1]),
            .id        (id_c[g+1]),
            .prio      (prio_c[g+1])
        );
    end

    always_comb begin
        count_next = count_reg;
        seq_next   = seq_reg;
        if (ctrl.insert) begin
            count_next = count_reg + CW'(1);
            seq_next   = seq_reg + ID_BITS'(1);
        end else if (ctrl.serve) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        m_data_next                = m_data_reg;
        m_valid_next               = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next                = 1'b1;
            m_data_next.entry_id        = '0;
            m_data_next.entry_priority  = '0;
            m_data_next.occupancy       = SPQ_OCC_W'(count_next);
            unique case (s_data.command)
                CMD_INSERT: begin
                    if (is_full) begin
                        m_data_next.status = ST_FULL;
                    end else begin
                        m_data_next.status         = ST_INSERTED;
                        m_data_next.entry_id       = SPQ_ID_W'(seq_reg);
                        m_data_next.entry_priority = SPQ_PRIO_W'(new_prio);
                    end
                end
                CMD_SERVE: begin
                    if (is_empty) begin
                        m_data_next.status = ST_EMPTY;
                    end else begin
                        m_data_next.status         = ST_SERVED;
                        m_data_next.entry_id       = SPQ_ID_W'(id_c[1]);
                        m_data_next.entry_priority = SPQ_PRIO_W'(prio_c[1]);
                    end
                end
                default: begin
                    m_data_next.status = ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            seq_reg     <= ID_BITS'(1);
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/spq_cell.sv
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS,
    parameter int ID_BITS       = SPQ_ID_BITS
) (
    input  logic                     aclk,
    input  spq_ctrl_t                ctrl,
    input  logic                     occupied,
    input  logic [ID_BITS-1:0]       new_id,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic                     prev_keep,
    input  logic [ID_BITS-1:0]       prev_id,
    input  logic [PRIORITY_BITS-1:0] prev_prio,
    input  logic [ID_BITS-1:0]       next_id,
    input  logic [PRIORITY_BITS-1:0] next_prio,
    output logic                     keep,
    output logic [ID_BITS-1:0]       id,
    output logic [PRIORITY_BITS-1:0] prio
);

    logic [ID_BITS-1:0]       id_reg, id_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;

    // held entries of greater or equal priority stay ahead of the newcomer
    assign keep = occupied && (prio_reg >= new_prio);

    always_comb begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ctrl.insert) begin
            if (!keep) begin
                if (prev_keep) begin
                    id_next   = new_id;
                    prio_next = new_prio;
                end else begin
                    id_next   = prev_id;
                    prio_next = prev_prio;
                end
            end
        end else if (ctrl.serve) begin
            id_next   = next_id;
            prio_next = next_prio;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign id   = id_reg;
    assign prio = prio_reg;

endmodule

>>> sv/spq_checker.sv
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input spq_out_t m_data
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // every accepted command yields a result on the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after accepted command");

    // a refused insert only happens with the store full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FULL) |->
            (m_data.occupancy == SPQ_OCC_W'(CAPACITY)) && (m_data.entry_id == '0))
        else $error("full status with spare room");

    // empty status reports nothing held and no entry
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_EMPTY) |->
            (m_data.occupancy == '0) && (m_data.entry_id == '0)
            && (m_data.entry_priority == '0))
        else $error("empty status with entries held");

endmodule

bind stable_priority_queue_top spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
